// File: rtl/fdm_pkg.sv
// ----------------------------------------------------------------------------
// fdm_pkg: shared types and constants
// Field widths, register codes and the structs passed between the
// filtered-derivative modules.
// ----------------------------------------------------------------------------
package fdm_pkg;

  localparam int unsigned CHANNELS_DEFAULT = 8;

  localparam int unsigned CHANNEL_W  = 3;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned TICKS_W    = 32;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned POLE_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // Room for eleven times a 32-bit tick count.
  localparam int unsigned BOUND_W = TICKS_W + 4;

  // Number of channel entries a 3-bit channel number can reach.
  localparam int unsigned CHANNEL_REACH = 1 << CHANNEL_W;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Configuration register codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_POLE   = 2'd1,
    REG_PERIOD = 2'd2
  } cfg_reg_t;

  // Coefficients and the precomputed timing window bounds.
  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [POLE_W-1:0]  pole;
    logic [BOUND_W-1:0] lo_bound;
    logic [BOUND_W-1:0] hi_bound;
  } cfg_t;

  // Per-channel history.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] last_sample;
    logic signed [SAMPLE_W-1:0] last_result;
  } chan_state_t;

  // One result.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] derivative;
    logic                       held;
    logic                       saturated;
  } result_t;

  // Ten times a tick count, as shifts and an add.
  function automatic logic [BOUND_W-1:0] times_ten(input logic [TICKS_W-1:0] ticks);
    logic [BOUND_W-1:0] wide;
    wide = {4'b0000, ticks};
    return (wide << 3) + (wide << 1);
  endfunction

endpackage

// File: rtl/fdm_cfg_regs.sv
// ----------------------------------------------------------------------------
// fdm_cfg_regs: configuration registers
// Holds the gain and pole coefficients and turns the sampling period into
// the lower and upper window bounds (9x and 11x) when it is written.
// ----------------------------------------------------------------------------
module fdm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [fdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdm_pkg::CFG_DATA_W-1:0] cfg_data,
  output fdm_pkg::cfg_t                  cfg
);
  import fdm_pkg::*;

  logic [BOUND_W-1:0] period_wide;
  logic [BOUND_W-1:0] lo_next;
  logic [BOUND_W-1:0] hi_next;

  // Window bounds from the written period.
  always_comb begin
    period_wide = {4'b0000, cfg_data[TICKS_W-1:0]};
    lo_next     = (period_wide << 3) + period_wide;
    hi_next     = (period_wide << 3) + (period_wide << 1) + period_wide;
  end

  // Register writes; index codes with no register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain     <= '0;
      cfg.pole     <= '0;
      cfg.lo_bound <= BOUND_W'(9);
      cfg.hi_bound <= BOUND_W'(11);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN:   cfg.gain <= cfg_data[GAIN_W-1:0];
        REG_POLE:   cfg.pole <= cfg_data[POLE_W-1:0];
        REG_PERIOD: begin
          cfg.lo_bound <= lo_next;
          cfg.hi_bound <= hi_next;
        end
        default: ;
      endcase
    end
  end

  // The upper bound never falls below the lower one.
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    cfg.hi_bound >= cfg.lo_bound)
    else $error("window upper bound below lower bound");

endmodule

// File: rtl/fdm_chan_store.sv
// ----------------------------------------------------------------------------
// fdm_chan_store: per-channel history store
// Last sample and last result of each channel, cleared by reset. One read
// port and one write port, both addressed by channel number.
// ----------------------------------------------------------------------------
module fdm_chan_store #(
  parameter int unsigned CHANNELS = fdm_pkg::CHANNELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fdm_pkg::CHANNEL_W-1:0] rd_channel,
  output logic                          rd_hit,
  output fdm_pkg::chan_state_t          rd_state,
  input  logic                          wr_en,
  input  logic [fdm_pkg::CHANNEL_W-1:0] wr_channel,
  input  fdm_pkg::chan_state_t          wr_state
);
  import fdm_pkg::*;

  // Channels beyond what the channel field can address hold no storage.
  localparam int unsigned DEPTH = (CHANNELS < CHANNEL_REACH) ? CHANNELS : CHANNEL_REACH;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CHANNEL_W:0] DEPTH_L = (CHANNEL_W + 1)'(DEPTH);

  chan_state_t      entries [DEPTH];
  logic             wr_hit;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  // Range check and index selection.
  always_comb begin
    rd_hit   = {1'b0, rd_channel} < DEPTH_L;
    wr_hit   = {1'b0, wr_channel} < DEPTH_L;
    rd_idx   = rd_hit ? rd_channel[IDX_W-1:0] : '0;
    wr_idx   = wr_hit ? wr_channel[IDX_W-1:0] : '0;
    rd_state = entries[rd_idx];
  end

  // Clear on reset, otherwise write the addressed entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= '0;
      end
    end else if (wr_en && wr_hit) begin
      entries[wr_idx] <= wr_state;
    end
  end

endmodule

// File: rtl/fdm_calc.sv
// ----------------------------------------------------------------------------
// fdm_calc: filter arithmetic
// Timing window test, the gain and pole products, truncation of the
// fraction bits and saturation to the sample range.
// ----------------------------------------------------------------------------
module fdm_calc (
  input  fdm_pkg::cfg_t                       cfg,
  input  logic signed [fdm_pkg::SAMPLE_W-1:0] sample,
  input  logic [fdm_pkg::TICKS_W-1:0]         elapsed_ticks,
  input  logic                                chan_hit,
  input  fdm_pkg::chan_state_t                state,
  output fdm_pkg::result_t                    res
);
  import fdm_pkg::*;

  localparam int unsigned DIFF_W  = SAMPLE_W + 1;
  localparam int unsigned PG_W    = GAIN_W + 1 + DIFF_W;
  localparam int unsigned PP_W    = POLE_W + 1 + SAMPLE_W;
  localparam int unsigned TG_W    = PG_W - FRAC_BITS;
  localparam int unsigned TP_W    = PP_W - FRAC_BITS;
  localparam int unsigned SUM_W   = TG_W + 1;

  logic [BOUND_W-1:0]      t10;
  logic                    in_window;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PG_W-1:0]  prod_gain;
  logic signed [PP_W-1:0]  prod_pole;
  logic signed [TG_W-1:0]  trunc_gain;
  logic signed [TP_W-1:0]  trunc_pole;
  logic signed [SUM_W-1:0] sum;
  logic                    fits;

  // Window test: strictly between 0.9 and 1.1 periods.
  always_comb begin
    t10       = times_ten(elapsed_ticks);
    in_window = (t10 > cfg.lo_bound) && (t10 < cfg.hi_bound);
  end

  // Products, floored by dropping the fraction bits, then summed.
  always_comb begin
    diff       = {sample[SAMPLE_W-1], sample} -
                 {state.last_sample[SAMPLE_W-1], state.last_sample};
    prod_gain  = $signed({1'b0, cfg.gain}) * diff;
    prod_pole  = $signed({1'b0, cfg.pole}) * state.last_result;
    trunc_gain = prod_gain[PG_W-1:FRAC_BITS];
    trunc_pole = prod_pole[PP_W-1:FRAC_BITS];
    sum        = {trunc_gain[TG_W-1], trunc_gain} +
                 {{(SUM_W - TP_W){trunc_pole[TP_W-1]}}, trunc_pole};
    fits       = (&sum[SUM_W-1:SAMPLE_W-1]) || !(|sum[SUM_W-1:SAMPLE_W-1]);
  end

  // Result selection: filtered value, held value or the empty result.
  always_comb begin
    res = '0;
    if (chan_hit) begin
      if (in_window) begin
        if (fits) begin
          res.derivative = sum[SAMPLE_W-1:0];
        end else begin
          res.derivative = sum[SUM_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
          res.saturated  = 1'b1;
        end
      end else begin
        res.derivative = state.last_result;
        res.held       = 1'b1;
      end
    end
  end

endmodule

// File: rtl/filtered_derivative_multichannel.sv
// ----------------------------------------------------------------------------
// filtered_derivative_multichannel: per-channel filtered differentiator
// Computes gain*(x - previous x) + pole*(previous y) per channel when the
// sample timing is within the window, otherwise repeats the previous output.
//
//   port group | direction | request moved
//   -----------+-----------+---------------------------------------------
//   in_*       | in        | channel, sample, elapsed_ticks
//   out_*      | out       | derivative, held, saturated
//   cfg_*      | in        | register write: index and data, no handshake
//
// One request is taken every cycle while in_stall is low. The accepting edge
// loads the input register, and the result register is loaded once it is
// free or its result is taken, which raises out_valid.
// The channel history is written at the same edge that loads the result, so
// back-to-back requests on one channel see each other's history.
// Reset clears the history, valid flags and coefficients; there is no sweep.
// in_stall rises only while both the input and result registers are full
// and out_stall holds the result.
// ----------------------------------------------------------------------------
module filtered_derivative_multichannel #(
  parameter int unsigned CHANNELS = fdm_pkg::CHANNELS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fdm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fdm_pkg::CHANNEL_W-1:0]       channel,
  input  logic signed [fdm_pkg::SAMPLE_W-1:0] sample,
  input  logic [fdm_pkg::TICKS_W-1:0]         elapsed_ticks,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fdm_pkg::SAMPLE_W-1:0] derivative,
  output logic                                held,
  output logic                                saturated
);
  import fdm_pkg::*;

  cfg_t                       cfg;
  logic                       iv;
  logic [CHANNEL_W-1:0]       in_ch;
  logic signed [SAMPLE_W-1:0] in_smp;
  logic [TICKS_W-1:0]         in_dt;
  logic                       advance;
  logic                       accept;
  logic                       chan_hit;
  chan_state_t                rd_state;
  chan_state_t                wr_state;
  result_t                    res;

  fdm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fdm_chan_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_channel (in_ch),
    .rd_hit     (chan_hit),
    .rd_state   (rd_state),
    .wr_en      (advance),
    .wr_channel (in_ch),
    .wr_state   (wr_state)
  );

  fdm_calc u_calc (
    .cfg           (cfg),
    .sample        (in_smp),
    .elapsed_ticks (in_dt),
    .chan_hit      (chan_hit),
    .state         (rd_state),
    .res           (res)
  );

  // Handshake: the input register moves on when the result register is free
  // or its result is being taken.
  always_comb begin
    advance  = iv && (!out_valid || !out_stall);
    in_stall = iv && !advance;
    accept   = in_valid && !in_stall;
    wr_state.last_sample = in_smp;
    wr_state.last_result = res.derivative;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (accept) begin
      iv <= 1'b1;
    end else if (advance) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_ch  <= channel;
      in_smp <= sample;
      in_dt  <= elapsed_ticks;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      derivative <= res.derivative;
      held       <= res.held;
      saturated  <= res.saturated;
    end
  end

  // A held result never reports saturation.
  a_held_not_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(held && saturated))
    else $error("held and saturated both set");

  // A saturated result sits at one end of the sample range.
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (derivative == SAMPLE_MAX || derivative == SAMPLE_MIN))
    else $error("saturated result not at range limit");

  // Every request moved out of the input register shows up as a result.
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register lost a request");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for filtered_derivative_multichannel
// Feeds per-channel sample requests through the valid/stall handshake with
// random gaps on both sides. Each accepted request is run through a local
// model of the filtered differentiator, and the outputs are compared in order.
// The run covers the timing window edges, floor rounding, saturation, a pole
// above one, a zero period and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import fdm_pkg::*;

  localparam int unsigned CHANNELS = 8;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int unsigned SEGMENTS      = 6;
  localparam int unsigned SEGMENT_ITEMS = 285;
  localparam int unsigned MAX_PRINTS    = 30;

  typedef struct packed {
    logic [CHANNEL_W-1:0]       chan;
    logic signed [SAMPLE_W-1:0] value;
    logic [TICKS_W-1:0]         ticks;
  } request_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CHANNEL_W-1:0]       channel = '0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [TICKS_W-1:0]         elapsed_ticks = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] derivative;
  logic                       held;
  logic                       saturated;

  // Requests waiting to be driven and results waiting to come out.
  request_t pending_requests[$];
  result_t  expected_results[$];

  // Model copy of the registers and the channel history.
  logic [GAIN_W-1:0]          model_gain = '0;
  logic [POLE_W-1:0]          model_pole = '0;
  logic [TICKS_W-1:0]         model_period = 32'd1;
  logic signed [SAMPLE_W-1:0] hist_sample[CHANNELS];
  logic signed [SAMPLE_W-1:0] hist_result[CHANNELS];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_held = 0;
  int unsigned n_sat = 0;
  int unsigned n_settings = 0;

  filtered_derivative_multichannel #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .channel(channel),
    .sample(sample),
    .elapsed_ticks(elapsed_ticks),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .derivative(derivative),
    .held(held),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Computes the result of one request and advances the channel history.
  function automatic result_t filter_step(input request_t r);
    result_t res;
    longint unsigned t10, lo, hi;
    longint x, d, g, p, prev_y, y;
    res = '0;
    if (r.chan < CHANNELS) begin
      t10 = r.ticks;
      lo = model_period;
      hi = model_period;
      t10 = t10 * 10;
      lo = lo * 9;
      hi = hi * 11;
      x = r.value;
      prev_y = hist_result[r.chan];
      if (t10 > lo && t10 < hi) begin
        // Each product is floored to 16 fraction bits before the sum.
        g = model_gain;
        p = model_pole;
        d = x - longint'(hist_sample[r.chan]);
        y = ((g * d) >>> FRAC_BITS) + ((p * prev_y) >>> FRAC_BITS);
        if (y > longint'(SAMPLE_MAX)) begin
          y = SAMPLE_MAX;
          res.saturated = 1'b1;
        end else if (y < longint'(SAMPLE_MIN)) begin
          y = SAMPLE_MIN;
          res.saturated = 1'b1;
        end
      end else begin
        y = prev_y;
        res.held = 1'b1;
      end
      res.derivative = y[SAMPLE_W-1:0];
      hist_sample[r.chan] = r.value;
      hist_result[r.chan] = y[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Random request whose timing mostly falls near or inside the window.
  function automatic request_t random_request(input logic [TICKS_W-1:0] period);
    request_t r;
    longint unsigned lo_t, hi_t;
    int unsigned pick;
    int signed small_v;
    lo_t = period;
    hi_t = period;
    lo_t = lo_t * 9 / 10;
    hi_t = hi_t * 11 / 10;
    if (hi_t > 64'hFFFF_FFFF) hi_t = 64'hFFFF_FFFF;
    r.chan = CHANNEL_W'($urandom_range(CHANNELS - 1));
    pick = $urandom_range(99);
    if (pick < 60) begin
      r.ticks = $urandom_range(32'(hi_t), 32'(lo_t));
    end else if (pick < 75) begin
      case ($urandom_range(3))
        0: r.ticks = 32'(lo_t);
        1: r.ticks = 32'(lo_t + 1);
        2: r.ticks = 32'(hi_t);
        default: r.ticks = 32'(hi_t + 1);
      endcase
    end else if (pick < 90) begin
      r.ticks = $urandom;
    end else begin
      case ($urandom_range(2))
        0: r.ticks = '0;
        1: r.ticks = '1;
        default: r.ticks = period;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 50) begin
      small_v = int'($urandom_range(2097152)) - 1048576;
      r.value = small_v;
    end else if (pick < 85) begin
      r.value = $urandom;
    end else begin
      case ($urandom_range(3))
        0: r.value = SAMPLE_MAX;
        1: r.value = SAMPLE_MIN;
        2: r.value = '0;
        default: r.value = '1;
      endcase
    end
    return r;
  endfunction

  task automatic push_request(input int unsigned ch, input logic [31:0] value,
                              input logic [31:0] ticks);
    request_t r;
    r.chan = CHANNEL_W'(ch);
    r.value = value;
    r.ticks = ticks;
    pending_requests.push_back(r);
  endtask

  // Waits until every request is accepted and every result has arrived.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // One register write; the model takes the same masked value.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_GAIN:   model_gain = data[GAIN_W-1:0];
      REG_POLE:   model_pole = data[POLE_W-1:0];
      REG_PERIOD: model_period = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Writes all registers, with junk in the unused upper bits.
  task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [POLE_W-1:0] pole,
                            input logic [TICKS_W-1:0] period);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_GAIN, {junk[31:24], gain});
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_POLE, {junk[14:0], pole});
    write_reg(REG_PERIOD, period);
    n_settings++;
    repeat (3) @(posedge clk);
  endtask

  // Request driver: holds a stalled request, otherwise presents the next one
  // or idles at random. The model runs on each accepted request.
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r.chan = channel;
        r.value = sample;
        r.ticks = elapsed_ticks;
        expected_results.push_back(filter_step(r));
        n_requests++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_requests.pop_front();
          channel <= r.chan;
          sample <= r.value;
          elapsed_ticks <= r.ticks;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random stall on the output side.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t: result with nothing expected: expected none, actual %0d",
                     $time, derivative);
        end else begin
          want = expected_results.pop_front();
          check_field("derivative", want.derivative, derivative);
          check_field("held", want.held, held);
          check_field("saturated", want.saturated, saturated);
          n_results++;
          if (want.held) n_held++;
          if (want.saturated) n_sat++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    logic [GAIN_W-1:0] gain;
    logic [POLE_W-1:0] pole;
    logic [TICKS_W-1:0] period;
    for (int i = 0; i < CHANNELS; i++) begin
      hist_sample[i] = '0;
      hist_result[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 13;
    recv_stall_pct = 45;

    // Unit gain, half pole, period of 100 ticks.
    set_config(24'd65536, 17'd32768, 32'd100);
    push_request(0, 32'h0001_0000, 100);
    push_request(0, 32'h0003_0000, 91);
    push_request(0, 32'h0005_0000, 90);
    push_request(0, 32'h0002_0000, 109);
    push_request(0, 32'h0004_0000, 110);
    push_request(1, 32'h0000_1234, 0);
    push_request(1, 32'hFFFF_0000, 32'hFFFF_FFFF);
    // Negative values check floor rounding of the pole product.
    push_request(2, -3, 100);
    push_request(2, -4, 100);
    // Full-scale swings saturate both ways.
    push_request(3, SAMPLE_MAX, 100);
    push_request(3, SAMPLE_MIN, 100);
    push_request(3, SAMPLE_MAX, 100);
    for (int ch = 4; ch < CHANNELS; ch++) push_request(ch, $urandom, 100);
    wait_idle();

    // Largest gain and period, pole above one.
    set_config(24'hFF_FFFF, 17'h1_FFFF, 32'hFFFF_FFFF);
    push_request(5, 32'h0000_0002, 32'hFFFF_FFFF);
    push_request(5, 32'h0000_0001, 32'hE666_6666);
    push_request(5, 32'hFFFF_FFFF, 32'hE666_6667);
    push_request(6, 32'h7FFF_0000, 32'hF000_0000);
    wait_idle();

    // Zero period: the window is empty.
    set_config(24'd65536, 17'd0, 32'd0);
    push_request(7, 32'h0010_0000, 0);
    push_request(7, 32'h0020_0000, 1);
    push_request(0, 32'h0030_0000, 100);
    wait_idle();

    // Random segments, each under its own register setting.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin gain = 24'd6553600; pole = 17'd655;   period = 32'd10; end
        2: begin gain = 24'd0;       pole = 17'd65536; period = 32'd1;  end
        3: begin gain = 24'hFF_FFFF; pole = 17'h1_FFFF; period = 32'hFFFF_FFFF; end
        4: begin gain = $urandom;    pole = $urandom_range(65536); period = 32'd0; end
        default: begin
          gain = $urandom;
          pole = $urandom_range(65536);
          period = $urandom_range(5000, 1);
        end
      endcase
      if (seg == 2) begin
        send_idle_pct = 45;
        recv_stall_pct = 13;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      set_config(gain, pole, period);
      for (int n = 0; n < SEGMENT_ITEMS; n++)
        pending_requests.push_back(random_request(period));
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d requests over %0d register settings and three idle patterns.",
             n_requests, n_settings);
    $display("Checked %0d results: %0d held, %0d saturated.", n_results, n_held, n_sat);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/fdm_pkg.sv
rtl/fdm_cfg_regs.sv
rtl/fdm_chan_store.sv
rtl/fdm_calc.sv
rtl/filtered_derivative_multichannel.sv
bench/tb_top.sv
